@@ rtl/core/psc_pkg.sv @@
// shared types, constants and helpers for the pressure sensor compensation block
package psc_pkg;

  // configuration register indexes
  localparam int unsigned NumCoef   = 5;
  localparam int unsigned CfgIdxW   = 3;
  localparam logic [CfgIdxW-1:0] CfgAc1Ac2 = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgAc3Ac4 = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgAc5Ac6 = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgB1B2   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMcMd   = 3'd4;

  // compensation constants
  localparam logic [31:0] TempOffs   = 32'd4000;
  localparam logic [31:0] PressScale = 32'd50000;
  localparam logic [31:0] PressC1    = 32'd3038;
  localparam logic [31:0] PressC2    = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] PressC3    = 32'd3791;
  localparam logic [31:0] B4Bias     = 32'd32768;
  localparam logic [31:0] B7Limit    = 32'h8000_0000;

  // temperature divider geometry: dividend magnitude stays below 2^26 + 1
  localparam int unsigned TempQuoW   = 27;

  // calibration coefficients as raw 16-bit halves
  typedef struct packed {
    logic [15:0] ac1;
    logic [15:0] ac2;
    logic [15:0] ac3;
    logic [15:0] ac4;
    logic [15:0] ac5;
    logic [15:0] ac6;
    logic [15:0] b1;
    logic [15:0] b2;
    logic [15:0] mc;
    logic [15:0] md;
  } coef_t;

  // what the temperature section hands to the pressure section
  typedef struct packed {
    logic [15:0] up;
    logic [31:0] temp;
    logic [31:0] b6;
    logic        fault;
  } mid_t;

  // sign extend a 16-bit half
  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  // arithmetic shift right of a 32-bit word
  function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
    asr = 32'($signed(v) >>> s);
  endfunction

endpackage

@@ rtl/core/psc_if.sv @@
// valid/ready channels for raw samples and compensated results
interface psc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_temp;
  logic [15:0] raw_press;
  modport source (output valid, raw_temp, raw_press, input ready);
  modport sink (input valid, raw_temp, raw_press, output ready);
endinterface

interface psc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] temperature_tenths;
  logic [31:0] pressure_pa;
  logic        divide_fault;
  modport source (output valid, temperature_tenths, pressure_pa, divide_fault, input ready);
  modport sink (input valid, temperature_tenths, pressure_pa, divide_fault, output ready);
endinterface

@@ rtl/core/psc_div.sv @@
// pipelined restoring unsigned divider, one quotient bit per stage
module psc_div #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 32,
  parameter int unsigned TW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] dvs_i,
  input  logic [TW-1:0] tag_i,
  output logic          valid_o,
  output logic [NW-1:0] quo_o,
  output logic [TW-1:0] tag_o
);

  logic          v_q   [NW];
  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] nq_q  [NW];
  logic [DW-1:0] dvs_q [NW];
  logic [TW-1:0] tag_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] rem_in;
    logic [NW-1:0] nq_in;
    logic [DW-1:0] dvs_in;
    logic [TW-1:0] tag_in;
    logic [DW:0]   sh;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign rem_in = '0;
      assign nq_in  = num_i;
      assign dvs_in = dvs_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign rem_in = rem_q[k-1];
      assign nq_in  = nq_q[k-1];
      assign dvs_in = dvs_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    // shift in next dividend bit, subtract when it fits
    assign sh   = {rem_in, nq_in[NW-1]};
    assign ge   = sh >= {1'b0, dvs_in};
    assign diff = sh - {1'b0, dvs_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k] <= ge ? diff[DW-1:0] : sh[DW-1:0];
        nq_q[k]  <= {nq_in[NW-2:0], ge};
        dvs_q[k] <= dvs_in;
        tag_q[k] <= tag_in;
      end
    end
  end

  assign valid_o = v_q[NW-1];
  assign quo_o   = nq_q[NW-1];
  assign tag_o   = tag_q[NW-1];

endmodule

@@ rtl/core/psc_temp.sv @@
// temperature section: x1, signed divide for x2, b5, temperature and b6
module psc_temp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  psc_pkg::coef_t    coef_i,
  input  logic              valid_i,
  input  logic [15:0]       raw_temp_i,
  input  logic [15:0]       raw_press_i,
  output logic              valid_o,
  output psc_pkg::mid_t     mid_o
);

  localparam int unsigned QW = psc_pkg::TempQuoW;
  localparam int unsigned TagW = 32 + 16 + 2;

  // stage 1: (ut - ac6) * ac5
  logic        s1_v_q;
  logic [31:0] s1_prod_q;
  logic [15:0] s1_up_q;
  logic [31:0] s1_diff;

  assign s1_diff = {16'b0, raw_temp_i} - {16'b0, coef_i.ac6};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv_i) begin
      s1_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_prod_q <= s1_diff * {16'b0, coef_i.ac5};
      s1_up_q   <= raw_press_i;
    end
  end

  // stage 2: x1, divisor and dividend magnitudes
  logic        s2_v_q;
  logic [31:0] s2_x1_q;
  logic [15:0] s2_up_q;
  logic [QW-1:0] s2_num_q;
  logic [31:0] s2_den_q;
  logic        s2_neg_q;
  logic        s2_fault_q;
  logic [31:0] s2_x1;
  logic [31:0] s2_den;
  logic [31:0] s2_num;
  logic [31:0] s2_num_mag;

  assign s2_x1      = psc_pkg::asr(s1_prod_q, 5'd15);
  assign s2_den     = s2_x1 + psc_pkg::sx16(coef_i.md);
  assign s2_num     = psc_pkg::sx16(coef_i.mc) << 11;
  assign s2_num_mag = s2_num[31] ? (32'd0 - s2_num) : s2_num;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (adv_i) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_x1_q    <= s2_x1;
      s2_up_q    <= s1_up_q;
      s2_num_q   <= s2_num_mag[QW-1:0];
      s2_den_q   <= s2_den[31] ? (32'd0 - s2_den) : s2_den;
      s2_neg_q   <= s2_num[31] ^ s2_den[31];
      s2_fault_q <= s2_den == 32'd0;
    end
  end

  // mc * 2048 / (x1 + md) on magnitudes
  logic          dv_v;
  logic [QW-1:0] dv_quo;
  logic [TagW-1:0] dv_tag;

  psc_div #(.NW(QW), .DW(32), .TW(TagW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv_i),
    .valid_i (s2_v_q),
    .num_i   (s2_num_q),
    .dvs_i   (s2_den_q),
    .tag_i   ({s2_x1_q, s2_up_q, s2_neg_q, s2_fault_q}),
    .valid_o (dv_v),
    .quo_o   (dv_quo),
    .tag_o   (dv_tag)
  );

  // stage 3: restore sign, b5 = x1 + x2
  logic        s3_v_q;
  logic [31:0] s3_b5_q;
  logic [15:0] s3_up_q;
  logic        s3_fault_q;
  logic [31:0] s3_q;

  assign s3_q = dv_tag[1] ? (32'd0 - {{(32-QW){1'b0}}, dv_quo})
                          : {{(32-QW){1'b0}}, dv_quo};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (adv_i) begin
      s3_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s3_b5_q    <= dv_tag[TagW-1 -: 32] + s3_q;
      s3_up_q    <= dv_tag[17:2];
      s3_fault_q <= dv_tag[0];
    end
  end

  // stage 4: temperature and b6
  logic  s4_v_q;
  psc_pkg::mid_t s4_mid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (adv_i) begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s4_mid_q.up    <= s3_up_q;
      s4_mid_q.temp  <= psc_pkg::asr(s3_b5_q + 32'd8, 5'd4);
      s4_mid_q.b6    <= s3_b5_q - psc_pkg::TempOffs;
      s4_mid_q.fault <= s3_fault_q;
    end
  end

  assign valid_o = s4_v_q;
  assign mid_o   = s4_mid_q;

endmodule

@@ rtl/core/psc_press.sv @@
// pressure section: b3, b4, b7, unsigned divide and final correction
module psc_press (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  psc_pkg::coef_t coef_i,
  input  logic           valid_i,
  input  psc_pkg::mid_t  mid_i,
  output logic           valid_o,
  output logic [31:0]    temp_o,
  output logic [31:0]    press_o,
  output logic           fault_o
);

  localparam int unsigned TagW = 32 + 2;

  // stage 1: b6 squared, ac2 * b6, ac3 * b6
  logic        p1_v_q;
  logic [31:0] p1_sq_q, p1_a2_q, p1_a3_q;
  psc_pkg::mid_t p1_mid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else if (adv_i) begin
      p1_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p1_sq_q  <= mid_i.b6 * mid_i.b6;
      p1_a2_q  <= psc_pkg::sx16(coef_i.ac2) * mid_i.b6;
      p1_a3_q  <= psc_pkg::sx16(coef_i.ac3) * mid_i.b6;
      p1_mid_q <= mid_i;
    end
  end

  // stage 2: sq terms times b2 and b1, ac2 and ac3 products shifted
  logic        p2_v_q;
  logic [31:0] p2_b2sq_q, p2_b1sq_q, p2_x2_q, p2_x1c_q;
  psc_pkg::mid_t p2_mid_q;
  logic [31:0] p2_sq;

  assign p2_sq = psc_pkg::asr(p1_sq_q, 5'd12);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_v_q <= 1'b0;
    end else if (adv_i) begin
      p2_v_q <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p2_b2sq_q <= psc_pkg::sx16(coef_i.b2) * p2_sq;
      p2_b1sq_q <= psc_pkg::sx16(coef_i.b1) * p2_sq;
      p2_x2_q   <= psc_pkg::asr(p1_a2_q, 5'd11);
      p2_x1c_q  <= psc_pkg::asr(p1_a3_q, 5'd13);
      p2_mid_q  <= p1_mid_q;
    end
  end

  // stage 3: b3 and the b4 correction term
  logic        p3_v_q;
  logic [31:0] p3_b3_q, p3_x3_q;
  psc_pkg::mid_t p3_mid_q;
  logic [31:0] p3_sum_b3, p3_sum_x3;

  assign p3_sum_b3 = (psc_pkg::sx16(coef_i.ac1) << 2) + psc_pkg::asr(p2_b2sq_q, 5'd11)
                     + p2_x2_q + 32'd2;
  assign p3_sum_x3 = p2_x1c_q + psc_pkg::asr(p2_b1sq_q, 5'd16) + 32'd2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_v_q <= 1'b0;
    end else if (adv_i) begin
      p3_v_q <= p2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p3_b3_q  <= psc_pkg::asr(p3_sum_b3, 5'd2);
      p3_x3_q  <= psc_pkg::asr(p3_sum_x3, 5'd2);
      p3_mid_q <= p2_mid_q;
    end
  end

  // stage 4: b4 and b7 products
  logic        p4_v_q;
  logic [31:0] p4_b4p_q, p4_b7_q;
  psc_pkg::mid_t p4_mid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p4_v_q <= 1'b0;
    end else if (adv_i) begin
      p4_v_q <= p3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p4_b4p_q <= {16'b0, coef_i.ac4} * (p3_x3_q + psc_pkg::B4Bias);
      p4_b7_q  <= ({16'b0, p3_mid_q.up} - p3_b3_q) * psc_pkg::PressScale;
      p4_mid_q <= p3_mid_q;
    end
  end

  // stage 5: divider operands, large b7 divides before doubling
  logic        p5_v_q;
  logic [31:0] p5_num_q, p5_dvs_q, p5_tmp_q;
  logic        p5_big_q, p5_fault_q;
  logic [31:0] p5_b4;
  logic        p5_big;

  assign p5_b4  = p4_b4p_q >> 15;
  assign p5_big = p4_b7_q >= psc_pkg::B7Limit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p5_v_q <= 1'b0;
    end else if (adv_i) begin
      p5_v_q <= p4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p5_num_q   <= p5_big ? p4_b7_q : (p4_b7_q << 1);
      p5_dvs_q   <= p5_b4;
      p5_tmp_q   <= p4_mid_q.temp;
      p5_big_q   <= p5_big;
      p5_fault_q <= p4_mid_q.fault | (p5_b4 == 32'd0);
    end
  end

  logic            dv_v;
  logic [31:0]     dv_quo;
  logic [TagW-1:0] dv_tag;

  psc_div #(.NW(32), .DW(32), .TW(TagW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv_i),
    .valid_i (p5_v_q),
    .num_i   (p5_num_q),
    .dvs_i   (p5_dvs_q),
    .tag_i   ({p5_tmp_q, p5_big_q, p5_fault_q}),
    .valid_o (dv_v),
    .quo_o   (dv_quo),
    .tag_o   (dv_tag)
  );

  // stage 6: raw pressure p
  logic        p6_v_q;
  logic [31:0] p6_p_q, p6_tmp_q;
  logic        p6_fault_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p6_v_q <= 1'b0;
    end else if (adv_i) begin
      p6_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p6_p_q     <= dv_tag[1] ? (dv_quo << 1) : dv_quo;
      p6_tmp_q   <= dv_tag[TagW-1 -: 32];
      p6_fault_q <= dv_tag[0];
    end
  end

  // stage 7: (p >> 8) squared and p * -7357
  logic        p7_v_q;
  logic [31:0] p7_p_q, p7_sq_q, p7_x2p_q, p7_tmp_q;
  logic        p7_fault_q;
  logic [31:0] p7_t8;

  assign p7_t8 = psc_pkg::asr(p6_p_q, 5'd8);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p7_v_q <= 1'b0;
    end else if (adv_i) begin
      p7_v_q <= p6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p7_p_q     <= p6_p_q;
      p7_sq_q    <= p7_t8 * p7_t8;
      p7_x2p_q   <= p6_p_q * psc_pkg::PressC2;
      p7_tmp_q   <= p6_tmp_q;
      p7_fault_q <= p6_fault_q;
    end
  end

  // stage 8: square times 3038, p * -7357 shifted down by 16
  logic        p8_v_q;
  logic [31:0] p8_p_q, p8_x1m_q, p8_x2_q, p8_tmp_q;
  logic        p8_fault_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p8_v_q <= 1'b0;
    end else if (adv_i) begin
      p8_v_q <= p7_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p8_p_q     <= p7_p_q;
      p8_x1m_q   <= p7_sq_q * psc_pkg::PressC1;
      p8_x2_q    <= psc_pkg::asr(p7_x2p_q, 5'd16);
      p8_tmp_q   <= p7_tmp_q;
      p8_fault_q <= p7_fault_q;
    end
  end

  // final correction, registered by the output stage
  logic [31:0] fin_sum;

  assign fin_sum = psc_pkg::asr(p8_x1m_q, 5'd16) + p8_x2_q + psc_pkg::PressC3;
  assign valid_o = p8_v_q;
  assign temp_o  = p8_tmp_q;
  assign press_o = p8_p_q + psc_pkg::asr(fin_sum, 5'd4);
  assign fault_o = p8_fault_q;

endmodule

@@ rtl/core/pressure_sensor_compensation_top.sv @@
// top level of the barometric pressure sensor compensation block
//
// sample_i carries one raw temperature word and one raw pressure word per
// transfer; result_o carries the compensated temperature in tenths of a
// degree, the pressure in pascals and a divide fault flag, one result per
// sample, in order. the five calibration registers are written through
// cfg_we_i / cfg_idx_i / cfg_data_i; the user must write them only while no
// sample is in flight, as the block does not enforce this; writes to
// indexes beyond the list are dropped. one sample is accepted every cycle
// while the receiver does not stall; the depth is set by the two pipelined
// dividers (27 stages for the temperature divide, 32 for the pressure
// divide) plus the multiply stages around them.
// reset clears the calibration registers and all stage valid bits; no
// clearing pass is needed. when the receiver stalls with a result waiting,
// the whole pipeline holds and sample_i.ready drops in the same cycle.
// a zero divisor sets divide_fault and forces both results to zero.
module pressure_sensor_compensation_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  psc_in_if.sink                        sample_i,
  psc_out_if.source                     result_o,
  input  logic                          cfg_we_i,
  input  logic [psc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [31:0]                   cfg_data_i
);

  // calibration registers
  logic [31:0] coef_q [psc_pkg::NumCoef];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < psc_pkg::NumCoef; i++) coef_q[i] <= 32'd0;
    end else if (cfg_we_i && (32'(cfg_idx_i) < psc_pkg::NumCoef)) begin
      coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  psc_pkg::coef_t coef;

  assign coef.ac1 = coef_q[psc_pkg::CfgAc1Ac2][31:16];
  assign coef.ac2 = coef_q[psc_pkg::CfgAc1Ac2][15:0];
  assign coef.ac3 = coef_q[psc_pkg::CfgAc3Ac4][31:16];
  assign coef.ac4 = coef_q[psc_pkg::CfgAc3Ac4][15:0];
  assign coef.ac5 = coef_q[psc_pkg::CfgAc5Ac6][31:16];
  assign coef.ac6 = coef_q[psc_pkg::CfgAc5Ac6][15:0];
  assign coef.b1  = coef_q[psc_pkg::CfgB1B2][31:16];
  assign coef.b2  = coef_q[psc_pkg::CfgB1B2][15:0];
  assign coef.mc  = coef_q[psc_pkg::CfgMcMd][31:16];
  assign coef.md  = coef_q[psc_pkg::CfgMcMd][15:0];

  // pipeline advances unless a result waits on a stalled receiver
  logic out_v_q;
  logic adv;

  assign adv            = !out_v_q || result_o.ready;
  assign sample_i.ready = adv;

  logic          mid_v;
  psc_pkg::mid_t mid;

  psc_temp u_temp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .coef_i      (coef),
    .valid_i     (sample_i.valid),
    .raw_temp_i  (sample_i.raw_temp),
    .raw_press_i (sample_i.raw_press),
    .valid_o     (mid_v),
    .mid_o       (mid)
  );

  logic        fin_v;
  logic [31:0] fin_temp, fin_press;
  logic        fin_fault;

  psc_press u_press (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .coef_i  (coef),
    .valid_i (mid_v),
    .mid_i   (mid),
    .valid_o (fin_v),
    .temp_o  (fin_temp),
    .press_o (fin_press),
    .fault_o (fin_fault)
  );

  // output register
  logic [31:0] out_temp_q, out_press_q;
  logic        out_fault_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= fin_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_temp_q  <= fin_fault ? 32'd0 : fin_temp;
      out_press_q <= fin_fault ? 32'd0 : fin_press;
      out_fault_q <= fin_fault;
    end
  end

  assign result_o.valid              = out_v_q;
  assign result_o.temperature_tenths = out_temp_q;
  assign result_o.pressure_pa        = out_press_q;
  assign result_o.divide_fault       = out_fault_q;

  // a faulted result carries zeros
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.divide_fault |->
      result_o.temperature_tenths == 32'd0 && result_o.pressure_pa == 32'd0)
    else $error("faulted result not zero");

  // a waiting result blocks new samples
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.ready |-> !sample_i.ready)
    else $error("sample taken during output stall");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !result_o.valid)
    else $error("result valid after reset");

endmodule
